// ----- hw/rtl/tsdg_pkg.sv -----
package tsdg_pkg;

  // Default depth of the delay ring, also the number of leading moves dropped.
  localparam int IGNORE_COUNT_DEF = 2;

  localparam int COORD_W   = 15;
  localparam int DIST_W    = 16;
  localparam int STATE_W   = 4;
  localparam int GESTURE_W = 4;
  localparam int NUM_STATES = 10;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIST = 1'd1;
  localparam logic [DIST_W-1:0]    MIN_DIST_RESET = 16'd10;

  // Request kinds on the input channel.
  localparam logic [1:0] ACT_RESET = 2'd0;
  localparam logic [1:0] ACT_DOWN  = 2'd1;
  localparam logic [1:0] ACT_MOVE  = 2'd2;
  localparam logic [1:0] ACT_UP    = 2'd3;

  // Compass directions, counterclockwise from east.
  typedef enum logic [2:0] {
    DIR_E  = 3'd0,
    DIR_NE = 3'd1,
    DIR_N  = 3'd2,
    DIR_NW = 3'd3,
    DIR_W  = 3'd4,
    DIR_SW = 3'd5,
    DIR_S  = 3'd6,
    DIR_SE = 3'd7
  } dir_t;

  typedef struct packed {
    logic [1:0]         action;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } in_t;

  typedef struct packed {
    logic [GESTURE_W-1:0] gesture;
    logic [COORD_W-1:0]   start_x;
    logic [COORD_W-1:0]   start_y;
  } out_t;

  // Last accepted point, handed from the stroke tracker to the quantizer.
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } point_t;

  // Quantizer verdict for one move.
  typedef struct packed {
    logic moved;
    dir_t dir;
  } quant_t;

  // Ten-state stroke table. State 0, like any code past the table, takes any
  // direction to a direction state, a direction state survives only the same
  // direction, and anything else falls into the dead state 1.
  function automatic logic [STATE_W-1:0] next_state(input logic [STATE_W-1:0] st,
                                                    input dir_t dir);
    logic [STATE_W-1:0] nx;
    nx = 4'd1;
    if (st == 4'd0 || st >= 4'(NUM_STATES)) begin
      nx = {1'b0, dir} + 4'd2;
    end else if (st >= 4'd2 && (st - 4'd2) == {1'b0, dir}) begin
      nx = st;
    end
    return nx;
  endfunction

endpackage

// ----- hw/rtl/tsdg_quant.sv -----
module tsdg_quant (
  input  tsdg_pkg::in_t                      item,
  input  tsdg_pkg::point_t                   last,
  input  logic [tsdg_pkg::DIST_W-1:0]        min_dist,
  output tsdg_pkg::quant_t                   quant
);

  logic signed [tsdg_pkg::DIST_W-1:0]  dx;
  logic signed [tsdg_pkg::DIST_W-1:0]  dy;
  logic [tsdg_pkg::COORD_W-1:0]        adx;
  logic [tsdg_pkg::COORD_W-1:0]        ady;
  logic [tsdg_pkg::COORD_W-1:0]        big;
  logic [tsdg_pkg::COORD_W-1:0]        diff;
  logic [tsdg_pkg::DIST_W-1:0]         span;
  logic                                diag;
  logic                                dx_pos;
  logic                                dy_pos;

  // Signed deltas and magnitudes from the last accepted point.
  always_comb begin
    dx     = $signed({1'b0, item.x}) - $signed({1'b0, last.x});
    dy     = $signed({1'b0, item.y}) - $signed({1'b0, last.y});
    adx    = dx[tsdg_pkg::DIST_W-1] ? tsdg_pkg::COORD_W'(-dx) : tsdg_pkg::COORD_W'(dx);
    ady    = dy[tsdg_pkg::DIST_W-1] ? tsdg_pkg::COORD_W'(-dy) : tsdg_pkg::COORD_W'(dy);
    span   = {1'b0, adx} + {1'b0, ady};
    dx_pos = !dx[tsdg_pkg::DIST_W-1] && (dx != '0);
    dy_pos = !dy[tsdg_pkg::DIST_W-1] && (dy != '0);
  end

  // A move is diagonal when the magnitudes differ by at most half the larger.
  always_comb begin
    if (adx > ady) begin
      big  = adx;
      diff = adx - ady;
    end else begin
      big  = ady;
      diff = ady - adx;
    end
    diag = diff <= (big >> 1);
  end

  // Pick one of the eight directions.
  always_comb begin
    quant.moved = span >= min_dist;
    if (diag) begin
      if (dx_pos) begin
        quant.dir = dy_pos ? tsdg_pkg::DIR_SE : tsdg_pkg::DIR_NE;
      end else begin
        quant.dir = dy_pos ? tsdg_pkg::DIR_SW : tsdg_pkg::DIR_NW;
      end
    end else if (adx > ady) begin
      quant.dir = dx_pos ? tsdg_pkg::DIR_E : tsdg_pkg::DIR_W;
    end else begin
      quant.dir = dy_pos ? tsdg_pkg::DIR_S : tsdg_pkg::DIR_N;
    end
  end

endmodule

// ----- hw/rtl/tsdg_stroke.sv -----
module tsdg_stroke #(
  parameter int IGNORE_COUNT = tsdg_pkg::IGNORE_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  tsdg_pkg::in_t     item,
  input  tsdg_pkg::quant_t  quant,
  output tsdg_pkg::point_t  last,
  output logic              res_valid,
  output tsdg_pkg::out_t    res
);

  localparam int MS_W = $clog2(2 * IGNORE_COUNT + 1);
  localparam logic [MS_W-1:0] MS_FILL = MS_W'(IGNORE_COUNT);
  localparam logic [MS_W-1:0] MS_FULL = MS_W'(2 * IGNORE_COUNT);

  logic [tsdg_pkg::STATE_W-1:0] cur_state_r;
  logic                         have_last_r;
  logic [MS_W-1:0]              moves_seen_r;
  logic [tsdg_pkg::STATE_W-1:0] ring_r [IGNORE_COUNT];
  tsdg_pkg::point_t             last_r;
  tsdg_pkg::point_t             origin_r;

  logic                         is_move;
  logic                         take_dir;
  logic [tsdg_pkg::STATE_W-1:0] ring_new;

  assign last    = last_r;
  assign is_move = step_en && (item.action == tsdg_pkg::ACT_MOVE);
  assign take_dir = is_move && have_last_r && quant.moved;

  // The newest ring entry is zero until the ring has seen a push.
  assign ring_new = tsdg_pkg::next_state(ring_r[IGNORE_COUNT-1], quant.dir);

  // Stroke control: state, move count and the delay ring.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_state_r  <= '0;
      have_last_r  <= 1'b0;
      moves_seen_r <= '0;
      for (int k = 0; k < IGNORE_COUNT; k++) begin
        ring_r[k] <= '0;
      end
    end else if (step_en && item.action == tsdg_pkg::ACT_RESET) begin
      cur_state_r  <= '0;
      have_last_r  <= 1'b0;
      moves_seen_r <= '0;
      for (int k = 0; k < IGNORE_COUNT; k++) begin
        ring_r[k] <= '0;
      end
    end else if (is_move && !have_last_r) begin
      have_last_r <= 1'b1;
    end else if (take_dir) begin
      if (moves_seen_r < MS_FULL) begin
        moves_seen_r <= moves_seen_r + 1'b1;
      end else begin
        cur_state_r <= ring_r[0];
      end
      if (moves_seen_r >= MS_FILL) begin
        for (int k = 0; k < IGNORE_COUNT - 1; k++) begin
          ring_r[k] <= ring_r[k+1];
        end
        ring_r[IGNORE_COUNT-1] <= ring_new;
      end
    end
  end

  // Point registers: the first move sets both, counted moves update the last.
  always_ff @(posedge clk) begin
    if (is_move && !have_last_r) begin
      last_r.x   <= item.x;
      last_r.y   <= item.y;
      origin_r.x <= item.x;
      origin_r.y <= item.y;
    end else if (take_dir) begin
      last_r.x <= item.x;
      last_r.y <= item.y;
    end
  end

  // Contact-up reports the gesture while a direction state is held.
  always_comb begin
    res_valid   = step_en && (item.action == tsdg_pkg::ACT_UP) &&
                  (cur_state_r inside {[4'd2:4'd9]});
    res.gesture = cur_state_r - 4'd1;
    res.start_x = origin_r.x;
    res.start_y = origin_r.y;
  end

endmodule

// ----- hw/rtl/touch_stroke_direction_gesture_unit.sv -----
// A contact-up request passes the input register, then the result register,
// before its result appears on out_valid. Throughput: one request per cycle
// while out_ready holds no result back; the stroke tracker updates in one pass.
// Reset (synchronous, rst_n low): the stroke is cleared, the block is
// disabled and min_distance returns to 10.
module touch_stroke_direction_gesture_unit #(
  parameter int IGNORE_COUNT = tsdg_pkg::IGNORE_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  tsdg_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output tsdg_pkg::out_t                      out_data,
  input  logic                                cfg_we,
  input  logic [tsdg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tsdg_pkg::DIST_W-1:0]         cfg_wdata
);

  logic                          enabled_r;
  logic [tsdg_pkg::DIST_W-1:0]   min_dist_r;
  logic                          s1_valid_r;
  tsdg_pkg::in_t                 s1_data_r;
  logic                          out_valid_r;
  tsdg_pkg::out_t                out_data_r;

  logic                          adv;
  logic                          step_en;
  tsdg_pkg::point_t              last;
  tsdg_pkg::quant_t              quant;
  logic                          res_valid;
  tsdg_pkg::out_t                res;

  // The input stage moves on whenever the result register can take a value.
  assign adv       = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || adv;
  assign step_en   = adv && enabled_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r  <= 1'b0;
      min_dist_r <= tsdg_pkg::MIN_DIST_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        tsdg_pkg::CFG_ENABLED:  enabled_r  <= cfg_wdata[0];
        tsdg_pkg::CFG_MIN_DIST: min_dist_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
  end

  tsdg_quant u_quant (
    .item     (s1_data_r),
    .last     (last),
    .min_dist (min_dist_r),
    .quant    (quant)
  );

  tsdg_stroke #(
    .IGNORE_COUNT (IGNORE_COUNT)
  ) u_stroke (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .item      (s1_data_r),
    .quant     (quant),
    .last      (last),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= res_valid;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_valid) begin
      out_data_r <= res;
    end
  end

  // A reported gesture is always one of the eight directions.
  a_gesture_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.gesture >= 4'd1 && out_data.gesture <= 4'd8))
    else $error("gesture code out of range");

  // A request taken while disabled never produces a result.
  a_disabled_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && !enabled_r) |=> !out_valid_r)
    else $error("result produced while disabled");

  // Backpressure reaches the input only when both stages are held.
  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r && !out_ready))
    else $error("input stalled without a full pipeline");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import tsdg_pkg::*;

  localparam int IGN          = IGNORE_COUNT_DEF;
  localparam int LONG_HOLD    = 300;
  localparam int SETTLE       = 4;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int RANDOM_ITEMS = 1200;
  localparam int COORD_MAX    = 32767;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_t                  in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_t                 out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIST_W-1:0]    cfg_wdata = '0;

  touch_stroke_direction_gesture_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Requests waiting to be driven, and gestures waiting to come out.
  in_t  pending[$];
  out_t gesture_q[$];
  int   queued_count = 0;
  int   taken_count = 0;
  int   errors = 0;
  int   cycle_count = 0;

  // Idle control used by the driver, the receiver, the monitor and the sequence.
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  bit long_hold_req = 1'b0;
  bit req_taken = 1'b0;
  int send_gap = 0;
  int hold_left = 0;

  // Shadow of the configuration registers.
  bit                en_shadow = 1'b0;
  logic [DIST_W-1:0] min_shadow = MIN_DIST_RESET;

  // Shadow of the stroke tracker.
  logic [STATE_W-1:0] cur_state = '0;
  logic [STATE_W-1:0] ring [IGN];
  bit                 have_pt = 1'b0;
  logic [COORD_W-1:0] pt_x = '0, pt_y = '0;
  logic [COORD_W-1:0] org_x = '0, org_y = '0;
  int                 moves_seen = 0;
  int                 head = 0, tail = 0;

  initial begin
    for (int i = 0; i < IGN; i++) ring[i] = '0;
  end

  // Mostly short gaps, a few long ones; none at all in steady mode.
  function automatic int pick_gap(input bit steady);
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // One step of the ten-state stroke table.
  function automatic logic [STATE_W-1:0] stroke_step(input logic [STATE_W-1:0] st,
                                                     input dir_t d);
    logic [STATE_W-1:0] entry;
    entry = {1'b0, d} + 4'd2;
    if (st == 4'd0 || st >= 4'(NUM_STATES)) return entry;
    if (st == entry) return st;
    return 4'd1;
  endfunction

  // Eight-way heading of a displacement; a move is diagonal when the two
  // magnitudes differ by at most half of the larger one.
  function automatic dir_t heading_of(input int dx, input int dy);
    int  adx, ady;
    bit  diag;
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    if (adx > ady) diag = (adx - ady) <= (adx / 2);
    else diag = (ady - adx) <= (ady / 2);
    if (diag) begin
      if (dx > 0) return (dy > 0) ? DIR_SE : DIR_NE;
      return (dy > 0) ? DIR_SW : DIR_NW;
    end
    if (adx > ady) return (dx > 0) ? DIR_E : DIR_W;
    return (dy > 0) ? DIR_S : DIR_N;
  endfunction

  task automatic clear_stroke();
    cur_state = '0;
    have_pt = 1'b0;
    moves_seen = 0;
    head = 0;
    tail = 0;
    for (int i = 0; i < IGN; i++) ring[i] = '0;
  endtask

  // The first moves are dropped, the next ones fill the delay ring, and
  // after that the current state lags the newest one by the ring depth.
  task automatic take_heading(input dir_t d);
    logic [STATE_W-1:0] prev;
    if (moves_seen >= 2 * IGN) begin
      cur_state = ring[head];
      ring[head] = stroke_step(ring[tail], d);
      head = (head + 1 >= IGN) ? 0 : head + 1;
      tail = (tail + 1 >= IGN) ? 0 : tail + 1;
    end else if (moves_seen >= IGN) begin
      prev = (tail == 0) ? 4'd0 : ring[tail - 1];
      ring[tail] = stroke_step(prev, d);
      moves_seen++;
      if (tail + 1 < IGN) tail++;
    end else begin
      moves_seen++;
    end
  endtask

  // Work out what one accepted request produces.
  task automatic track_request(input in_t req);
    int   dx, dy, span;
    out_t res;
    if (!en_shadow) return;
    case (req.action)
      ACT_RESET: clear_stroke();
      ACT_DOWN: ;
      ACT_UP: begin
        if (cur_state >= 4'd2 && cur_state < 4'(NUM_STATES)) begin
          res.gesture = cur_state - 4'd1;
          res.start_x = org_x;
          res.start_y = org_y;
          gesture_q.push_back(res);
        end
      end
      ACT_MOVE: begin
        if (!have_pt) begin
          have_pt = 1'b1;
          pt_x = req.x;
          pt_y = req.y;
          org_x = req.x;
          org_y = req.y;
        end else begin
          dx = int'(req.x) - int'(pt_x);
          dy = int'(req.y) - int'(pt_y);
          span = ((dx < 0) ? -dx : dx) + ((dy < 0) ? -dy : dy);
          if (span >= int'(min_shadow)) begin
            take_heading(heading_of(dx, dy));
            pt_x = req.x;
            pt_y = req.y;
          end
        end
      end
    endcase
  endtask

  // Request driver: holds each request until it is taken, then idles.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      req_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending.size() != 0) begin
        in_data <= pending.pop_front();
        in_valid <= 1'b1;
        send_gap = pick_gap(tx_steady);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls plus an occasional long hold-off.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left = LONG_HOLD - 1;
      out_ready <= 1'b0;
    end else begin
      hold_left = pick_gap(rx_steady);
      out_ready <= (hold_left == 0);
    end
  end

  // Monitor: predicts on each accepted request, checks each accepted gesture.
  always @(posedge clk) begin
    out_t want;
    if (rst_n && in_valid && in_ready) begin
      track_request(in_data);
      req_taken = 1'b1;
      taken_count++;
    end
    if (rst_n && out_valid && out_ready) begin
      if (gesture_q.size() == 0) begin
        $error("unexpected gesture %0d at (%0d, %0d)",
               out_data.gesture, out_data.start_x, out_data.start_y);
        errors++;
      end else begin
        want = gesture_q.pop_front();
        if (out_data.gesture !== want.gesture) begin
          $error("gesture: expected %0d, got %0d", want.gesture, out_data.gesture);
          errors++;
        end
        if (out_data.start_x !== want.start_x) begin
          $error("start_x: expected %0d, got %0d", want.start_x, out_data.start_x);
          errors++;
        end
        if (out_data.start_y !== want.start_y) begin
          $error("start_y: expected %0d, got %0d", want.start_y, out_data.start_y);
          errors++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic int clamp_coord(input int v);
    if (v < 0) return 0;
    if (v > COORD_MAX) return COORD_MAX;
    return v;
  endfunction

  function automatic int rnd_coord();
    return $urandom_range(0, COORD_MAX);
  endfunction

  task automatic push_req(input logic [1:0] act, input int x, input int y);
    in_t req;
    req.action = act;
    req.x = x[COORD_W-1:0];
    req.y = y[COORD_W-1:0];
    pending.push_back(req);
    queued_count++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[DIST_W-1:0];
    if (idx == CFG_ENABLED) en_shadow = val[0];
    else min_shadow = val[DIST_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every request is taken and every gesture has come out.
  task automatic wait_idle();
    do @(negedge clk);
    while (taken_count != queued_count || gesture_q.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic unit_step(input dir_t d, output int ux, output int uy);
    case (d)
      DIR_E:  begin ux = 1;  uy = 0;  end
      DIR_NE: begin ux = 1;  uy = -1; end
      DIR_N:  begin ux = 0;  uy = -1; end
      DIR_NW: begin ux = -1; uy = -1; end
      DIR_W:  begin ux = -1; uy = 0;  end
      DIR_SW: begin ux = -1; uy = 1;  end
      DIR_S:  begin ux = 0;  uy = 1;  end
      default: begin ux = 1; uy = 1;  end
    endcase
  endtask

  // A mostly straight stroke with random content, some turns, short moves
  // and early lifts mixed in.
  task automatic push_stroke();
    dir_t d;
    int   n, mag, px, py, ux, uy, sx, sy;
    if ($urandom_range(0, 5) != 0) push_req(ACT_RESET, rnd_coord(), rnd_coord());
    if ($urandom_range(0, 3) == 0) push_req(ACT_DOWN, rnd_coord(), rnd_coord());
    d = dir_t'($urandom_range(0, 7));
    unit_step(d, ux, uy);
    mag = int'(min_shadow) + $urandom_range(0, 40);
    n = (mag > 1500) ? $urandom_range(1, 4) : $urandom_range(3, 11);
    px = (ux > 0) ? $urandom_range(0, 16383) :
         (ux < 0) ? $urandom_range(16384, COORD_MAX) : rnd_coord();
    py = (uy > 0) ? $urandom_range(0, 16383) :
         (uy < 0) ? $urandom_range(16384, COORD_MAX) : rnd_coord();
    push_req(ACT_MOVE, px, py);
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 15))
        0: begin
          d = dir_t'($urandom_range(0, 7));
          unit_step(d, ux, uy);
        end
        1: push_req(ACT_UP, rnd_coord(), rnd_coord());
        2: push_req(ACT_MOVE, clamp_coord(px + 1), py);
        default: ;
      endcase
      if (ux != 0 && uy != 0) begin
        sx = ux * (mag / 2 + 1);
        sy = uy * (mag / 2 + 1);
      end else begin
        sx = ux * mag;
        sy = uy * mag;
      end
      if ($urandom_range(0, 3) == 0) begin
        sx += int'($urandom_range(0, 6)) - 3;
        sy += int'($urandom_range(0, 6)) - 3;
      end
      px = clamp_coord(px + sx);
      py = clamp_coord(py + sy);
      push_req(ACT_MOVE, px, py);
    end
    push_req(ACT_UP, rnd_coord(), rnd_coord());
    if ($urandom_range(0, 4) == 0) push_req(ACT_UP, rnd_coord(), rnd_coord());
  endtask

  // Stimulus sequence.
  initial begin
    int base, live_items, pick;
    live_items = 0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Disabled after reset: everything is ignored.
    push_req(ACT_RESET, 0, 0);
    push_req(ACT_MOVE, 100, 100);
    push_req(ACT_MOVE, 300, 100);
    push_req(ACT_UP, 0, 0);
    wait_idle();

    // Lift before any move, then a clean rightward stroke, then a move after
    // the lift that continues the same stroke.
    write_reg(CFG_ENABLED, 1);
    push_req(ACT_UP, COORD_MAX, COORD_MAX);
    push_req(ACT_MOVE, 0, 0);
    for (int k = 1; k <= 5; k++) begin
      push_req(ACT_MOVE, 20 * k, 0);
      if (k == 2) push_req(ACT_DOWN, 0, 0);
    end
    push_req(ACT_UP, 0, 0);
    push_req(ACT_MOVE, COORD_MAX, COORD_MAX);
    push_req(ACT_UP, 0, 0);
    wait_idle();

    // Zero distance threshold: moves that do not move still count.
    write_reg(CFG_MIN_DIST, 0);
    push_req(ACT_RESET, 0, 0);
    repeat (6) push_req(ACT_MOVE, COORD_MAX, COORD_MAX);
    push_req(ACT_UP, 0, 0);
    wait_idle();

    // Largest reachable distance, then a threshold nothing can reach.
    write_reg(CFG_MIN_DIST, 65534);
    push_req(ACT_RESET, 0, 0);
    push_req(ACT_MOVE, 0, 0);
    push_req(ACT_MOVE, COORD_MAX, COORD_MAX);
    push_req(ACT_UP, 0, 0);
    wait_idle();
    write_reg(CFG_MIN_DIST, 65535);
    push_req(ACT_RESET, 0, 0);
    push_req(ACT_MOVE, 0, 0);
    push_req(ACT_MOVE, COORD_MAX, COORD_MAX);
    push_req(ACT_UP, 0, 0);
    wait_idle();

    // Receiver holds off while many lifts of an upward stroke pile up.
    write_reg(CFG_MIN_DIST, 10);
    tx_steady = 1'b1;
    long_hold_req = 1'b1;
    push_req(ACT_RESET, 0, 0);
    push_req(ACT_MOVE, 1000, 1000);
    for (int k = 1; k <= 6; k++) push_req(ACT_MOVE, 1000, 1000 - 30 * k);
    repeat (40) push_req(ACT_UP, rnd_coord(), rnd_coord());
    wait_idle();

    // Random phases, each under its own register setting and idle mode.
    while (live_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0: write_reg(CFG_MIN_DIST, 0);
        1: write_reg(CFG_MIN_DIST, 1);
        5: write_reg(CFG_MIN_DIST, $urandom_range(2, 60));
        6: write_reg(CFG_MIN_DIST, $urandom_range(61, 400));
        7: write_reg(CFG_MIN_DIST, $urandom_range(401, 3000));
        8: write_reg(CFG_MIN_DIST, 65534);
        9: write_reg(CFG_MIN_DIST, 65535);
        default: write_reg(CFG_MIN_DIST, 10);
      endcase
      write_reg(CFG_ENABLED, ($urandom_range(0, 7) != 0) ? 1 : 0);
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      base = queued_count;
      repeat ($urandom_range(4, 10)) begin
        push_stroke();
        if ($urandom_range(0, 4) == 0)
          push_req(2'($urandom_range(0, 3)), rnd_coord(), rnd_coord());
      end
      live_items += queued_count - base;
      wait_idle();
    end

    repeat (10) @(negedge clk);
    if (errors == 0 && gesture_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- touch_stroke_direction_gesture_unit.f -----
hw/rtl/tsdg_pkg.sv
hw/rtl/tsdg_quant.sv
hw/rtl/tsdg_stroke.sv
hw/rtl/touch_stroke_direction_gesture_unit.sv
tb/tb_top.sv
